>>> src/rde_pkg.sv
// Shared types, constants and index helpers for the reversible deque engine.
// No dependencies; every other file except rde_ram imports this package.
package rde_pkg;

  // Storage geometry
  localparam int DEPTH = 1024;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int VW    = 16;

  typedef logic [AW-1:0] idx_t;
  typedef logic [CW-1:0] cnt_t;
  typedef logic [VW-1:0] val_t;

  // Operation codes
  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_REVERSE = 3'd1,
    OP_DELETE  = 3'd2,
    OP_READ    = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ERROR = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Store access issued by the controller in the accept cycle
  typedef struct packed {
    logic we;
    idx_t addr;
    val_t wdata;
  } mem_cmd_t;

  // Result fields known in the accept cycle; element follows from the store
  typedef struct packed {
    status_t status;
    cnt_t    remaining;
    logic    is_read;
  } res_t;

  // Circular index arithmetic, valid for any depth
  function automatic idx_t wrap_add(idx_t a, idx_t b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic idx_t wrap_inc(idx_t a);
    return (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic idx_t wrap_dec(idx_t a);
    return (a == '0) ? AW'(DEPTH - 1) : a - 1'b1;
  endfunction

endpackage

>>> src/rde_if.sv
// Valid/ready channel interfaces for the request and response beats.
// Depends on rde_pkg for field widths.
interface rde_req_if import rde_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  val_t       item_value;

  modport source (output valid, output operation, output item_value, input ready);
  modport sink   (input valid, input operation, input item_value, output ready);
endinterface

interface rde_rsp_if import rde_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] status;
  val_t       element;
  cnt_t       remaining;

  modport source (output valid, output status, output element, output remaining, input ready);
  modport sink   (input valid, input status, input element, input remaining, output ready);
endinterface

>>> src/rde_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No package dependency.
module rde_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                          wdata,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> src/rde_ctrl.sv
// Deque pointer state and per-beat decode: updates low index, count and flags,
// and issues the store access. Depends on rde_pkg.
module rde_ctrl import rde_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [2:0] operation,
  input  val_t       item_value,
  output mem_cmd_t   mem_cmd,
  output res_t       res
);

  idx_t low, low_next;
  cnt_t count, count_next;
  logic reversed, reversed_next;
  logic err, err_next;

  cnt_t count_m1;
  idx_t high, tail;

  assign count_m1 = count - 1'b1;
  assign high     = wrap_add(low, count_m1[AW-1:0]);
  assign tail     = wrap_add(low, count[AW-1:0]);

  // Next state and store access
  always_comb begin
    low_next       = low;
    count_next     = count;
    reversed_next  = reversed;
    err_next       = err;
    mem_cmd.we     = 1'b0;
    mem_cmd.addr   = low;
    mem_cmd.wdata  = item_value;
    res.status     = ST_OK;
    res.is_read    = 1'b0;
    priority if (operation == OP_CLEAR) begin
      low_next      = '0;
      count_next    = '0;
      reversed_next = 1'b0;
      err_next      = 1'b0;
    end else if (err) begin
      res.status = ST_ERROR;
    end else begin
      unique case (operation)
        OP_LOAD: begin
          if (count == CW'(DEPTH)) begin
            res.status = ST_FULL;
          end else begin
            mem_cmd.we = 1'b1;
            if (!reversed) begin
              mem_cmd.addr = tail;
            end else begin
              low_next     = wrap_dec(low);
              mem_cmd.addr = wrap_dec(low);
            end
            count_next = count + 1'b1;
          end
        end
        OP_REVERSE: begin
          reversed_next = !reversed;
        end
        OP_DELETE, OP_READ: begin
          if (count == '0) begin
            if (operation == OP_DELETE) begin
              err_next   = 1'b1;
              res.status = ST_ERROR;
            end else begin
              res.status = ST_EMPTY;
            end
          end else begin
            // take the logical front
            res.is_read = (operation == OP_READ);
            if (!reversed) begin
              mem_cmd.addr = low;
              low_next     = wrap_inc(low);
            end else begin
              mem_cmd.addr = high;
            end
            count_next = count_m1;
          end
        end
        default: begin
          // unused codes change nothing
        end
      endcase
    end
    res.remaining = count_next;
    if (!accept) begin
      mem_cmd.we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low      <= '0;
      count    <= '0;
      reversed <= 1'b0;
      err      <= 1'b0;
    end else if (accept) begin
      low      <= low_next;
      count    <= count_next;
      reversed <= reversed_next;
      err      <= err_next;
    end
  end

endmodule

>>> src/reversible_deque_engine.sv
// Top level of the reversible deque engine: controller, element store and
// result staging. Depends on rde_pkg, rde_if, rde_ram and rde_ctrl.
//
// Usage:
//   req carries one operation beat (operation, item_value); rsp returns one
//   beat per request (status, element, remaining), in request order.
//   Operations: load, reverse, delete front, read next, clear. Reverse is
//   lazy: only an orientation flag flips, elements are never moved.
// Pipeline: an accepted request's result is registered in the pending
//   stage, which waits for the store's registered read data, and then
//   moves to the output register that drives rsp. The store is a
//   single-port RAM with registered read data.
// Throughput: one request per cycle while rsp is taken. The single store
//   port serves one access per beat, and the pointers are updated in the
//   accept cycle, so back-to-back beats see up-to-date state.
// Stall: when rsp.ready is low the output register holds its beat, the
//   pending stage holds the next one with its captured read data, and
//   req.ready drops until the output register frees up.
// Reset: rst (synchronous, active high) empties the deque, clears the error
//   flag and the orientation, and drops both response stages. Store
//   contents are not cleared; no entry is read before it is written.
module reversible_deque_engine import rde_pkg::*; (
  input logic     clk,
  input logic     rst,
  rde_req_if.sink   req,
  rde_rsp_if.source rsp
);

  mem_cmd_t mem_cmd;
  res_t     res;
  val_t     ram_rdata;

  logic accept;
  logic out_free;
  logic pend_move;

  // pending stage, waits on store read data
  logic    pend_valid;
  logic    pend_fresh;
  logic    pend_read;
  status_t pend_status;
  cnt_t    pend_remaining;
  val_t    pend_elem;
  val_t    pend_elem_cur;

  // output register
  logic    out_valid;
  status_t out_status;
  cnt_t    out_remaining;
  val_t    out_elem;

  // Handshake
  assign out_free  = !out_valid || rsp.ready;
  assign pend_move = pend_valid && out_free;
  assign req.ready = !pend_valid || out_free;
  assign accept    = req.valid && req.ready;

  rde_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .operation  (req.operation),
    .item_value (req.item_value),
    .mem_cmd    (mem_cmd),
    .res        (res)
  );

  rde_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_cmd.we),
    .addr  (mem_cmd.addr),
    .wdata (mem_cmd.wdata),
    .rdata (ram_rdata)
  );

  // Read data is live only in the cycle after the read; capture it then
  assign pend_elem_cur = pend_fresh ? (pend_read ? ram_rdata : '0) : pend_elem;

  // Stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      pend_fresh <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (pend_move) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        pend_valid <= 1'b1;
        pend_fresh <= 1'b1;
      end else begin
        pend_fresh <= 1'b0;
        if (pend_move) begin
          pend_valid <= 1'b0;
        end
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    pend_elem <= pend_elem_cur;
    if (accept) begin
      pend_read      <= res.is_read;
      pend_status    <= res.status;
      pend_remaining <= res.remaining;
    end
    if (pend_move) begin
      out_status    <= pend_status;
      out_remaining <= pend_remaining;
      out_elem      <= pend_elem_cur;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.element   = out_elem;
  assign rsp.remaining = out_remaining;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_remaining <= CW'(DEPTH))
    else $error("remaining count above store depth");

  a_elem_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_OK) |-> out_elem == '0)
    else $error("nonzero element on a failed beat");

  a_pend_hold: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && !out_free) |=> pend_valid)
    else $error("pending result dropped while output stalled");

  a_read_fresh: assert property (@(posedge clk) disable iff (rst)
    accept |=> (pend_valid && pend_fresh))
    else $error("accepted beat did not enter pending stage");

endmodule

>>> tb/tb_reversible_deque_engine.sv
// Self-checking testbench for reversible_deque_engine: directed table, a fill
// to capacity, then weighted random traffic. Needs rde_pkg, rde_if and the RTL.
module tb_reversible_deque_engine;
  import rde_pkg::*;

  localparam int RAND_ITEMS = 420;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_DIRECTED = 24;

  // Opcodes the block treats as no-ops
  localparam logic [2:0] OP_SPARE5 = 3'd5;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  typedef struct packed {
    status_t status;
    val_t    element;
    cnt_t    remaining;
  } rsp_beat_t;

  typedef struct packed {
    logic [2:0] op;
    val_t       value;
    logic       pinned;
    status_t    status;
    val_t       element;
    cnt_t       remaining;
  } step_row_t;

  logic clk;
  logic rst;

  rde_req_if req_ch ();
  rde_rsp_if rsp_ch ();

  reversible_deque_engine DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the deque
  val_t    shadow_mem [DEPTH];
  idx_t    shadow_low;
  cnt_t    shadow_cnt;
  logic    shadow_rev;
  logic    shadow_err;

  rsp_beat_t pending_q [$];
  rsp_beat_t pin_res;
  logic      pin_valid;

  int src_idle_pct;
  int sink_idle_pct;
  int fail_count;
  int beats_in;
  int status_seen [4];
  int cycle_cnt;

  // Directed rows; pinned rows carry a hand-written expectation
  step_row_t directed_rows [N_DIRECTED] = '{
    '{OP_READ,    16'h0000, 1'b1, ST_EMPTY, 16'h0000, 11'd0},
    '{OP_REVERSE, 16'h0000, 1'b1, ST_OK,    16'h0000, 11'd0},
    '{OP_LOAD,    16'hFFFF, 1'b1, ST_OK,    16'h0000, 11'd1},  // low end wraps down
    '{OP_LOAD,    16'h0000, 1'b1, ST_OK,    16'h0000, 11'd2},
    '{OP_LOAD,    16'h1234, 1'b1, ST_OK,    16'h0000, 11'd3},
    '{OP_READ,    16'h0000, 1'b1, ST_OK,    16'hFFFF, 11'd2},  // reversed front = high end
    '{OP_REVERSE, 16'h0000, 1'b0, ST_OK,    16'h0000, 11'd0},
    '{OP_READ,    16'h0000, 1'b1, ST_OK,    16'h1234, 11'd1},
    '{OP_LOAD,    16'h8001, 1'b0, ST_OK,    16'h0000, 11'd0},
    '{OP_LOAD,    16'h7FFE, 1'b0, ST_OK,    16'h0000, 11'd0},  // high end wraps to 0
    '{OP_DELETE,  16'h0000, 1'b0, ST_OK,    16'h0000, 11'd0},
    '{OP_SPARE5,  16'hFFFF, 1'b0, ST_OK,    16'h0000, 11'd0},
    '{OP_SPARE6,  16'h0000, 1'b0, ST_OK,    16'h0000, 11'd0},
    '{OP_SPARE7,  16'h5A5A, 1'b0, ST_OK,    16'h0000, 11'd0},
    '{OP_READ,    16'h0000, 1'b0, ST_OK,    16'h0000, 11'd0},
    '{OP_READ,    16'h0000, 1'b0, ST_OK,    16'h0000, 11'd0},
    '{OP_READ,    16'h0000, 1'b1, ST_EMPTY, 16'h0000, 11'd0},
    '{OP_DELETE,  16'h0000, 1'b1, ST_ERROR, 16'h0000, 11'd0},  // sets sticky error
    '{OP_LOAD,    16'h5555, 1'b1, ST_ERROR, 16'h0000, 11'd0},
    '{OP_SPARE7,  16'h0000, 1'b1, ST_ERROR, 16'h0000, 11'd0},
    '{OP_READ,    16'h0000, 1'b1, ST_ERROR, 16'h0000, 11'd0},
    '{OP_CLEAR,   16'h0000, 1'b1, ST_OK,    16'h0000, 11'd0},
    '{OP_LOAD,    16'hAAAA, 1'b1, ST_OK,    16'h0000, 11'd1},
    '{OP_CLEAR,   16'hFFFF, 1'b1, ST_OK,    16'h0000, 11'd0}
  };

  // Apply one operation to the shadow deque and return the result it causes
  function automatic rsp_beat_t deque_apply(input logic [2:0] op, input val_t v);
    rsp_beat_t r;
    int        pos;
    r.status  = ST_OK;
    r.element = '0;
    if (op == OP_CLEAR) begin
      shadow_low = '0;
      shadow_cnt = '0;
      shadow_rev = 1'b0;
      shadow_err = 1'b0;
    end else if (shadow_err) begin
      r.status = ST_ERROR;
    end else begin
      case (op)
        OP_LOAD: begin
          if (shadow_cnt >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            if (!shadow_rev) begin
              pos = (int'(shadow_low) + int'(shadow_cnt)) % DEPTH;
            end else begin
              pos = (int'(shadow_low) + DEPTH - 1) % DEPTH;
              shadow_low = idx_t'(pos);
            end
            shadow_mem[pos] = v;
            shadow_cnt = shadow_cnt + 1'b1;
          end
        end
        OP_REVERSE: shadow_rev = ~shadow_rev;
        OP_DELETE, OP_READ: begin
          if (shadow_cnt == 0) begin
            if (op == OP_DELETE) begin
              shadow_err = 1'b1;
              r.status = ST_ERROR;
            end else begin
              r.status = ST_EMPTY;
            end
          end else begin
            // front is the low end when forward, the high end when reversed
            if (!shadow_rev) begin
              pos = int'(shadow_low);
              shadow_low = idx_t'((pos + 1) % DEPTH);
            end else begin
              pos = (int'(shadow_low) + int'(shadow_cnt) - 1) % DEPTH;
            end
            if (op == OP_READ) begin
              r.element = shadow_mem[pos];
            end
            shadow_cnt = shadow_cnt - 1'b1;
          end
        end
        default: ;
      endcase
    end
    r.remaining = shadow_cnt;
    return r;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: ready changes at the falling edge
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("%0t timeout with %0d beats outstanding", $time, pending_q.size());
    $display("tb: failure");
    $finish;
  end

  // Monitor: predict on each request beat, check each response beat
  always @(posedge clk) begin : monitor
    rsp_beat_t want;
    rsp_beat_t got;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        want = deque_apply(req_ch.operation, req_ch.item_value);
        if (pin_valid) begin
          want = pin_res;
        end
        pending_q = {pending_q, want};
        status_seen[want.status]++;
        beats_in++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status    = status_t'(rsp_ch.status);
        got.element   = rsp_ch.element;
        got.remaining = rsp_ch.remaining;
        if (pending_q.size() == 0) begin
          $display("%0t unexpected beat: expected none, got status %0d element %h remaining %0d",
                   $time, got.status, got.element, got.remaining);
          fail_count++;
        end else begin
          want = pending_q.pop_front();
          if (got.status != want.status) begin
            $display("%0t status mismatch: expected %0d, got %0d",
                     $time, want.status, got.status);
            fail_count++;
          end
          if (got.element != want.element) begin
            $display("%0t element mismatch: expected %h, got %h",
                     $time, want.element, got.element);
            fail_count++;
          end
          if (got.remaining != want.remaining) begin
            $display("%0t remaining mismatch: expected %0d, got %0d",
                     $time, want.remaining, got.remaining);
            fail_count++;
          end
        end
      end
    end
  end

  // Send one beat after a random gap; returns at the falling edge after acceptance
  task automatic send_op(input logic [2:0] op, input val_t v, input logic pinned,
                         input rsp_beat_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid      = 1'b1;
    req_ch.operation  = op;
    req_ch.item_value = v;
    pin_valid         = pinned;
    pin_res           = r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off the sender until every outstanding result is back
  task automatic wait_drained();
    req_ch.valid = 1'b0;
    pin_valid    = 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Weighted opcode choice; growth phases favor loads, shrink phases removals
  function automatic logic [2:0] pick_op(input logic grow);
    int roll;
    roll = $urandom_range(99);
    if (shadow_err) begin
      return ($urandom_range(1) == 1) ? OP_CLEAR : 3'($urandom_range(7));
    end
    if (grow) begin
      if (roll < 70) return OP_LOAD;
      if (roll < 78) return OP_REVERSE;
      if (roll < 85) return OP_DELETE;
      if (roll < 97) return OP_READ;
      if (roll < 98) return OP_CLEAR;
    end else begin
      if (roll < 20) return OP_LOAD;
      if (roll < 30) return OP_REVERSE;
      if (roll < 52) return OP_DELETE;
      if (roll < 94) return OP_READ;
      if (roll < 96) return OP_CLEAR;
    end
    case ($urandom_range(2))
      0:       return OP_SPARE5;
      1:       return OP_SPARE6;
      default: return OP_SPARE7;
    endcase
  endfunction

  // Stimulus
  initial begin : stimulus
    rsp_beat_t  no_pin;
    logic [2:0] op;
    val_t       v;
    int         useful;
    int         seg_left;
    int         stage;
    logic       grow;
    no_pin            = '0;
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.operation  = OP_LOAD;
    req_ch.item_value = '0;
    pin_valid         = 1'b0;
    pin_res           = '0;
    src_idle_pct      = 16;
    sink_idle_pct     = 59;
    fail_count        = 0;
    beats_in          = 0;
    status_seen       = '{0, 0, 0, 0};
    shadow_low        = '0;
    shadow_cnt        = '0;
    shadow_rev        = 1'b0;
    shadow_err        = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table
    foreach (directed_rows[i]) begin
      send_op(directed_rows[i].op, directed_rows[i].value, directed_rows[i].pinned,
              '{directed_rows[i].status, directed_rows[i].element,
                directed_rows[i].remaining});
    end
    wait_drained();

    // Fill to capacity, flipping orientation halfway, then overrun by three
    for (int k = 0; k < DEPTH + 3; k++) begin
      if (k == DEPTH / 2) begin
        send_op(OP_REVERSE, val_t'($urandom), 1'b0, no_pin);
      end
      send_op(OP_LOAD, val_t'($urandom), 1'b0, no_pin);
    end
    wait_drained();

    // Random traffic in alternating grow/shrink segments, three idle profiles
    useful   = 0;
    seg_left = 0;
    stage    = 0;
    grow     = 1'b1;
    while (useful < RAND_ITEMS) begin
      if (useful * 3 / RAND_ITEMS != stage) begin
        wait_drained();
        stage = useful * 3 / RAND_ITEMS;
        src_idle_pct  = (stage == 1) ? 59 : 0;
        sink_idle_pct = (stage == 1) ? 16 : 0;
      end
      if (seg_left == 0) begin
        grow     = ~grow;
        seg_left = $urandom_range(20, 300);
      end
      op = pick_op(grow);
      case ($urandom_range(9))
        0:       v = 16'h0000;
        1:       v = 16'hFFFF;
        default: v = val_t'($urandom);
      endcase
      if (!shadow_err || op == OP_CLEAR) begin
        useful++;
      end
      send_op(op, v, 1'b0, no_pin);
      seg_left--;
      if ($urandom_range(199) == 0) begin
        wait_drained();
      end
    end

    // Let everything come back, then watch for stray beats
    wait_drained();
    repeat (8) @(posedge clk);
    $display("tb: %0d beats checked: %0d ok, %0d error, %0d empty, %0d full",
             beats_in, status_seen[ST_OK], status_seen[ST_ERROR],
             status_seen[ST_EMPTY], status_seen[ST_FULL]);
    $display("tb: deque filled to %0d entries, both orientations, wrap on both ends",
             DEPTH);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
